### rtl/mmc_pkg.sv
// ----------------------------------------------------------------------------
// mmc_pkg
// Shared widths, register indexes, reset values and the sequencer state type
// of the magnetometer min/max calibrator.
// ----------------------------------------------------------------------------
package mmc_pkg;

    localparam int RAW_W      = 16;
    localparam int RADIUS_W   = 15;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;

    // Shared multiplier: 18-bit signed by 17-bit signed.
    localparam int MUL_A_W = RAW_W + 2;
    localparam int MUL_B_W = RAW_W + 1;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int MAG2_W  = 2 * RAW_W;

    localparam int OFS_W   = RAW_W + 1;
    localparam int SCALE_W = 16;
    localparam int FRAC_W  = 15;
    localparam int TOTAL_W = RAW_W + 2;

    // Scale divider: (total << 15 + 3*span) / (6*span).
    localparam int DIV_NUM_W = TOTAL_W + FRAC_W + 1;
    localparam int DIV_DEN_W = RAW_W + 3;
    localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

    localparam int STEP_W = 3;
    localparam int AXIS_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_TARGET   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_AXIS_RADIUS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_VALID_MAG   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_VALID_MAG   = 2'd3;

    localparam logic [15:0]         RST_SAMPLE_TARGET = 16'd1000;
    localparam logic [RADIUS_W-1:0] RST_MIN_RADIUS    = 15'd50;
    localparam logic [15:0]         RST_MIN_MAG       = 16'd0;
    localparam logic [15:0]         RST_MAX_MAG       = 16'd56756;

    localparam logic [SCALE_W-1:0]     SCALE_ONE   = 16'd16384;
    localparam logic signed [RAW_W-1:0] AXIS_MIN_RST = 16'sh7FFF;
    localparam logic signed [RAW_W-1:0] AXIS_MAX_RST = 16'sh8000;

    localparam logic [STEP_W-1:0] MAG_LAST_STEP   = 3'd5;
    localparam logic [STEP_W-1:0] APPLY_LAST_STEP = 3'd3;
    localparam logic [AXIS_W-1:0] LAST_AXIS       = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MAG,
        ST_UPDATE,
        ST_EVAL,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_APPLY,
        ST_OUT
    } t_state;

endpackage

### rtl/mmc_mul.sv
// ----------------------------------------------------------------------------
// mmc_mul
// Shared signed multiplier with a registered product, used for the squared
// magnitude terms and for applying offset and scale to each axis.
// ----------------------------------------------------------------------------
module mmc_mul (
    input  logic                                i_clk,
    input  logic signed [mmc_pkg::MUL_A_W-1:0]  i_a,
    input  logic signed [mmc_pkg::MUL_B_W-1:0]  i_b,
    output logic signed [mmc_pkg::PROD_W-1:0]   o_prod
);
    import mmc_pkg::*;

    logic signed [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_a) * PROD_W'(i_b);
    end

    assign o_prod = r_prod;

endmodule

### rtl/mmc_div.sv
// ----------------------------------------------------------------------------
// mmc_div
// Restoring radix-2 divider, one quotient bit per cycle. The quotient is
// saturated to the scale width. A zero divisor yields all ones.
// ----------------------------------------------------------------------------
module mmc_div (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [mmc_pkg::DIV_NUM_W-1:0]      i_num,
    input  logic [mmc_pkg::DIV_DEN_W-1:0]      i_den,
    output logic                               o_done,
    output logic [mmc_pkg::SCALE_W-1:0]        o_quot
);
    import mmc_pkg::*;

    logic                   r_busy;
    logic                   r_done;
    logic [DIV_CNT_W-1:0]   r_cnt;
    logic [DIV_NUM_W-1:0]   r_num;
    logic [DIV_DEN_W-1:0]   r_den;
    logic [DIV_DEN_W-1:0]   r_rem;
    logic [DIV_NUM_W-1:0]   r_quot;

    logic [DIV_DEN_W:0]     c_rem_sh;
    logic                   c_ge;

    assign c_rem_sh = {r_rem, r_num[DIV_NUM_W-1]};
    assign c_ge     = c_rem_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num  <= i_num;
            r_den  <= i_den;
            r_rem  <= '0;
            r_quot <= '0;
        end else if (r_busy) begin
            r_num  <= {r_num[DIV_NUM_W-2:0], 1'b0};
            r_quot <= {r_quot[DIV_NUM_W-2:0], c_ge};
            if (c_ge) begin
                r_rem <= DIV_DEN_W'(c_rem_sh - {1'b0, r_den});
            end else begin
                r_rem <= c_rem_sh[DIV_DEN_W-1:0];
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = (r_quot[DIV_NUM_W-1:SCALE_W] != '0) ? '1 : r_quot[SCALE_W-1:0];

endmodule

### rtl/magnetometer_minmax_calibrator_core.sv
// ----------------------------------------------------------------------------
// magnetometer_minmax_calibrator_core
// Hard and soft iron min/max calibration of a three-axis magnetometer.
//
// Input channel (i_in_valid / o_in_stall) carries either a raw sample
// (i_mode = 0) or a start-calibration command (i_mode = 1). Every item
// produces exactly one result on the output channel (o_out_valid /
// i_out_stall). A transfer happens when valid is high and stall is low.
// The block works on one item at a time; o_in_stall is high from the
// transfer until the result has been written to the output register.
// A start command goes straight to the output state. A sample sends five
// products and three offset/scale products through one shared multiplier.
// The sample that completes a calibration run also runs the scale divider
// once per axis. The result register is separate from the sequencer, so a
// new item is taken while a finished result waits; if the receiver keeps
// stalling, the next result waits in the sequencer and o_in_stall stays
// high. Configuration writes through i_cfg_we take effect at once and are
// meant only while the block is idle. Synchronous reset restores the
// register defaults and leaves the block uncalibrated and not collecting.
// ----------------------------------------------------------------------------
module magnetometer_minmax_calibrator_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [mmc_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [mmc_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic                                 i_mode,
    input  logic signed [mmc_pkg::RAW_W-1:0]     i_raw_x,
    input  logic signed [mmc_pkg::RAW_W-1:0]     i_raw_y,
    input  logic signed [mmc_pkg::RAW_W-1:0]     i_raw_z,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [mmc_pkg::RAW_W-1:0]     o_field_x,
    output logic signed [mmc_pkg::RAW_W-1:0]     o_field_y,
    output logic signed [mmc_pkg::RAW_W-1:0]     o_field_z,
    output logic                                 o_sample_valid,
    output logic                                 o_is_calibrated,
    output logic                                 o_calibrating,
    output logic [15:0]                          o_samples_taken,
    output logic                                 o_range_rejected,
    output logic                                 o_calibration_done
);
    import mmc_pkg::*;

    // Configuration registers
    logic [15:0]          r_sample_target;
    logic [RADIUS_W-1:0]  r_min_radius;
    logic [15:0]          r_min_mag;
    logic [15:0]          r_max_mag;

    // Calibration state
    logic signed [RAW_W-1:0] r_axis_min [3];
    logic signed [RAW_W-1:0] r_axis_max [3];
    logic [15:0]             r_valid_count;
    logic signed [OFS_W-1:0] r_offset [3];
    logic [SCALE_W-1:0]      r_scale [3];
    logic                    r_collecting;
    logic                    r_calibrated;

    // Sequencer and working registers
    t_state                  r_state, n_state;
    logic [STEP_W-1:0]       r_step;
    logic [AXIS_W-1:0]       r_axis;
    logic signed [RAW_W-1:0] r_raw [3];
    logic signed [RAW_W-1:0] r_field [3];
    logic [MAG2_W-1:0]       r_mag;
    logic [MAG2_W-1:0]       r_lo2;
    logic [MAG2_W-1:0]       r_hi2;
    logic                    r_valid;
    logic                    r_go;
    logic                    r_rej;
    logic                    r_done;
    logic [TOTAL_W-1:0]      r_total;

    // Output register
    logic                    r_out_valid;
    logic signed [RAW_W-1:0] r_o_field [3];
    logic                    r_o_sample_valid;
    logic                    r_o_is_calibrated;
    logic                    r_o_calibrating;
    logic [15:0]             r_o_samples_taken;
    logic                    r_o_range_rejected;
    logic                    r_o_calibration_done;

    // Combinational signals
    logic                      c_in_accept;
    logic                      c_out_load;
    logic                      c_div_start;
    logic signed [MUL_A_W-1:0] c_mul_a;
    logic signed [MUL_B_W-1:0] c_mul_b;
    logic signed [PROD_W-1:0]  c_prod;
    logic                      c_div_done;
    logic [SCALE_W-1:0]        c_div_quot;
    logic [DIV_NUM_W-1:0]      c_div_num;
    logic [DIV_DEN_W-1:0]      c_div_den;
    logic [RAW_W-1:0]          c_span [3];
    logic [TOTAL_W-1:0]        c_total;
    logic                      c_small;
    logic                      c_mag_ok;
    logic                      c_reached;
    logic [TOTAL_W-1:0]        c_span3;
    logic [AXIS_W-1:0]         c_ax;
    logic [AXIS_W-1:0]         c_prev_ax;
    logic                      c_applied;

    function automatic logic signed [RAW_W-1:0] sat_field(
        input logic signed [PROD_W-1:0] p
    );
        logic signed [PROD_W-FRAC_W-1:0] q;
        logic signed [RAW_W-1:0]         res;
        q = p[PROD_W-1:FRAC_W];
        if (q[PROD_W-FRAC_W-1:RAW_W-1] == '0 || q[PROD_W-FRAC_W-1:RAW_W-1] == '1) begin
            res = q[RAW_W-1:0];
        end else if (q[PROD_W-FRAC_W-1]) begin
            res = {1'b1, {(RAW_W-1){1'b0}}};
        end else begin
            res = {1'b0, {(RAW_W-1){1'b1}}};
        end
        return res;
    endfunction

    mmc_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (c_mul_a),
        .i_b    (c_mul_b),
        .o_prod (c_prod)
    );

    mmc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (c_div_start),
        .i_num   (c_div_num),
        .i_den   (c_div_den),
        .o_done  (c_div_done),
        .o_quot  (c_div_quot)
    );

    assign c_ax      = r_step[AXIS_W-1:0];
    assign c_prev_ax = AXIS_W'(r_step - 1'b1);
    assign c_applied = r_valid && r_calibrated;
    assign c_mag_ok  = (r_mag >= r_lo2) && (r_mag <= r_hi2);
    assign c_reached = r_valid_count >= r_sample_target;

    // Span of each axis, their sum, and the too-small test.
    always_comb begin
        logic signed [RAW_W:0] d;
        c_total = '0;
        c_small = 1'b0;
        for (int i = 0; i < 3; i++) begin
            d = {r_axis_max[i][RAW_W-1], r_axis_max[i]}
              - {r_axis_min[i][RAW_W-1], r_axis_min[i]};
            c_span[i] = (d > 0) ? d[RAW_W-1:0] : '0;
            c_total   = c_total + TOTAL_W'(c_span[i]);
            if ({1'b0, c_span[i]} < {r_min_radius, 1'b0}) begin
                c_small = 1'b1;
            end
        end
    end

    // Divider operands: (total << 15) + 3*span over 6*span, which rounds
    // half up the ratio (total/3) / span in Q2.14.
    assign c_span3   = {1'b0, c_span[r_axis], 1'b0} + {2'b00, c_span[r_axis]};
    assign c_div_den = {c_span3, 1'b0};
    assign c_div_num = {1'b0, r_total, {FRAC_W{1'b0}}} + DIV_NUM_W'(c_span3);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (c_in_accept) begin
                    n_state = i_mode ? ST_OUT : ST_MAG;
                end
            end
            ST_MAG: begin
                if (r_step == MAG_LAST_STEP) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: n_state = ST_EVAL;
            ST_EVAL: begin
                if (r_go && c_reached && !c_small) begin
                    n_state = ST_DIV_START;
                end else begin
                    n_state = ST_APPLY;
                end
            end
            ST_DIV_START: n_state = ST_DIV_WAIT;
            ST_DIV_WAIT: begin
                if (c_div_done) begin
                    n_state = (r_axis == LAST_AXIS) ? ST_APPLY : ST_DIV_START;
                end
            end
            ST_APPLY: begin
                if (r_step == APPLY_LAST_STEP) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (c_out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        o_in_stall  = 1'b1;
        c_div_start = 1'b0;
        c_out_load  = 1'b0;
        c_mul_a     = '0;
        c_mul_b     = '0;
        unique case (r_state)
            ST_IDLE: o_in_stall = 1'b0;
            ST_MAG: begin
                case (r_step)
                    3'd0, 3'd1, 3'd2: begin
                        c_mul_a = MUL_A_W'(r_raw[c_ax]);
                        c_mul_b = MUL_B_W'(r_raw[c_ax]);
                    end
                    3'd3: begin
                        c_mul_a = {2'b00, r_min_mag};
                        c_mul_b = {1'b0, r_min_mag};
                    end
                    3'd4: begin
                        c_mul_a = {2'b00, r_max_mag};
                        c_mul_b = {1'b0, r_max_mag};
                    end
                    default: begin
                        c_mul_a = '0;
                        c_mul_b = '0;
                    end
                endcase
            end
            ST_DIV_START: c_div_start = 1'b1;
            ST_APPLY: begin
                if (r_step < APPLY_LAST_STEP) begin
                    c_mul_a = {r_raw[c_ax][RAW_W-1], r_raw[c_ax], 1'b0}
                            - {r_offset[c_ax][OFS_W-1], r_offset[c_ax]};
                    c_mul_b = {1'b0, r_scale[c_ax]};
                end
            end
            ST_OUT: c_out_load = !r_out_valid || !i_out_stall;
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    assign c_in_accept = i_in_valid && !o_in_stall;

    // Control and calibration state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_IDLE;
            r_step          <= '0;
            r_axis          <= '0;
            r_out_valid     <= 1'b0;
            r_sample_target <= RST_SAMPLE_TARGET;
            r_min_radius    <= RST_MIN_RADIUS;
            r_min_mag       <= RST_MIN_MAG;
            r_max_mag       <= RST_MAX_MAG;
            r_valid_count   <= '0;
            r_collecting    <= 1'b0;
            r_calibrated    <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_axis_min[i] <= AXIS_MIN_RST;
                r_axis_max[i] <= AXIS_MAX_RST;
                r_offset[i]   <= '0;
                r_scale[i]    <= SCALE_ONE;
            end
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_SAMPLE_TARGET:   r_sample_target <= i_cfg_data;
                    REG_MIN_AXIS_RADIUS: r_min_radius    <= i_cfg_data[RADIUS_W-1:0];
                    REG_MIN_VALID_MAG:   r_min_mag       <= i_cfg_data;
                    REG_MAX_VALID_MAG:   r_max_mag       <= i_cfg_data;
                    default: ;
                endcase
            end

            if (c_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    r_step <= '0;
                    if (c_in_accept && i_mode) begin
                        r_calibrated  <= 1'b0;
                        r_collecting  <= 1'b1;
                        r_valid_count <= '0;
                        for (int i = 0; i < 3; i++) begin
                            r_axis_min[i] <= AXIS_MIN_RST;
                            r_axis_max[i] <= AXIS_MAX_RST;
                            r_offset[i]   <= '0;
                            r_scale[i]    <= SCALE_ONE;
                        end
                    end
                end
                ST_MAG: begin
                    r_step <= (r_step == MAG_LAST_STEP) ? '0 : r_step + 1'b1;
                end
                ST_UPDATE: begin
                    if (c_mag_ok && r_collecting) begin
                        for (int i = 0; i < 3; i++) begin
                            if (r_raw[i] < r_axis_min[i]) r_axis_min[i] <= r_raw[i];
                            if (r_raw[i] > r_axis_max[i]) r_axis_max[i] <= r_raw[i];
                        end
                        if (r_valid_count != '1) begin
                            r_valid_count <= r_valid_count + 1'b1;
                        end
                    end
                end
                ST_EVAL: begin
                    r_step <= '0;
                    r_axis <= '0;
                    if (r_go && c_reached) begin
                        if (c_small) begin
                            r_valid_count <= '0;
                            for (int i = 0; i < 3; i++) begin
                                r_axis_min[i] <= AXIS_MIN_RST;
                                r_axis_max[i] <= AXIS_MAX_RST;
                            end
                        end else begin
                            r_collecting <= 1'b0;
                            r_calibrated <= 1'b1;
                            for (int i = 0; i < 3; i++) begin
                                r_offset[i] <= {r_axis_max[i][RAW_W-1], r_axis_max[i]}
                                             + {r_axis_min[i][RAW_W-1], r_axis_min[i]};
                            end
                        end
                    end
                end
                ST_DIV_START: ;
                ST_DIV_WAIT: begin
                    if (c_div_done) begin
                        r_scale[r_axis] <= c_div_quot;
                        r_axis          <= r_axis + 1'b1;
                    end
                end
                ST_APPLY: begin
                    r_step <= r_step + 1'b1;
                end
                ST_OUT: ;
                default: ;
            endcase
        end
    end

    // Working payload registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (c_in_accept) begin
                    r_raw[0] <= i_raw_x;
                    r_raw[1] <= i_raw_y;
                    r_raw[2] <= i_raw_z;
                    r_mag    <= '0;
                    r_rej    <= 1'b0;
                    r_done   <= 1'b0;
                    r_valid  <= 1'b0;
                    if (i_mode) begin
                        for (int i = 0; i < 3; i++) r_field[i] <= '0;
                    end else begin
                        r_field[0] <= i_raw_x;
                        r_field[1] <= i_raw_y;
                        r_field[2] <= i_raw_z;
                    end
                end
            end
            ST_MAG: begin
                // Each product lands in the cycle after its operands are issued.
                case (r_step)
                    3'd1, 3'd2, 3'd3: r_mag <= r_mag + c_prod[MAG2_W-1:0];
                    3'd4:             r_lo2 <= c_prod[MAG2_W-1:0];
                    3'd5:             r_hi2 <= c_prod[MAG2_W-1:0];
                    default: ;
                endcase
            end
            ST_UPDATE: begin
                r_valid <= c_mag_ok;
                r_go    <= c_mag_ok && r_collecting;
            end
            ST_EVAL: begin
                r_total <= c_total;
                if (r_go && c_reached) begin
                    r_rej  <= c_small;
                    r_done <= !c_small;
                end
            end
            ST_APPLY: begin
                if (r_step != '0 && c_applied) begin
                    r_field[c_prev_ax] <= sat_field(c_prod);
                end
            end
            default: ;
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (c_out_load) begin
            for (int i = 0; i < 3; i++) r_o_field[i] <= r_field[i];
            r_o_sample_valid     <= r_valid;
            r_o_is_calibrated    <= c_applied;
            r_o_calibrating      <= r_collecting;
            r_o_samples_taken    <= r_valid_count;
            r_o_range_rejected   <= r_rej;
            r_o_calibration_done <= r_done;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_field_x          = r_o_field[0];
    assign o_field_y          = r_o_field[1];
    assign o_field_z          = r_o_field[2];
    assign o_sample_valid     = r_o_sample_valid;
    assign o_is_calibrated    = r_o_is_calibrated;
    assign o_calibrating      = r_o_calibrating;
    assign o_samples_taken    = r_o_samples_taken;
    assign o_range_rejected   = r_o_range_rejected;
    assign o_calibration_done = r_o_calibration_done;

endmodule

### verif/tb_magnetometer_minmax_calibrator_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_magnetometer_minmax_calibrator_core
// Self-checking bench for the min/max magnetometer calibrator. A short
// table of directed items exercises the magnitude bounds, calibration
// completion, short span restarts, zero span and output saturation.
// Random phases with fresh register settings follow, mostly well-formed
// point clouds mixed with noise and start commands. Every result is
// compared with fixed values or a cycle-free calibration model. Both
// handshakes see random idle bursts, and there is one long output hold-off.
// ----------------------------------------------------------------------------
module tb_magnetometer_minmax_calibrator_core;

    import mmc_pkg::*;

    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_START  = 1'b1;
    localparam int   ITEM_GOAL   = 1750;
    localparam int   CALM_ITEMS  = 200;
    localparam int   LONG_HOLD   = 400;
    localparam int   CYCLE_LIMIT = 600000;

    typedef struct packed {
        logic signed [15:0] fx;
        logic signed [15:0] fy;
        logic signed [15:0] fz;
        logic               sample_valid;
        logic               is_cal;
        logic               calibrating;
        logic [15:0]        taken;
        logic               rejected;
        logic               done;
    } t_reading;

    typedef struct packed {
        logic               is_cfg;
        logic [15:0]        target;
        logic [15:0]        radius;
        logic [15:0]        min_mag;
        logic [15:0]        max_mag;
        logic               mode;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic               typed;
        t_reading           want;
    } t_stim_row;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_cfg_we;
    logic [CFG_IDX_W-1:0]      i_cfg_index;
    logic [CFG_DATA_W-1:0]     i_cfg_data;
    logic                      i_in_valid;
    logic                      o_in_stall;
    logic                      i_mode;
    logic signed [RAW_W-1:0]   i_raw_x;
    logic signed [RAW_W-1:0]   i_raw_y;
    logic signed [RAW_W-1:0]   i_raw_z;
    logic                      o_out_valid;
    logic                      i_out_stall;
    logic signed [RAW_W-1:0]   o_field_x;
    logic signed [RAW_W-1:0]   o_field_y;
    logic signed [RAW_W-1:0]   o_field_z;
    logic                      o_sample_valid;
    logic                      o_is_calibrated;
    logic                      o_calibrating;
    logic [15:0]               o_samples_taken;
    logic                      o_range_rejected;
    logic                      o_calibration_done;

    magnetometer_minmax_calibrator_core dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_mode             (i_mode),
        .i_raw_x            (i_raw_x),
        .i_raw_y            (i_raw_y),
        .i_raw_z            (i_raw_z),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_field_x          (o_field_x),
        .o_field_y          (o_field_y),
        .o_field_z          (o_field_z),
        .o_sample_valid     (o_sample_valid),
        .o_is_calibrated    (o_is_calibrated),
        .o_calibrating      (o_calibrating),
        .o_samples_taken    (o_samples_taken),
        .o_range_rejected   (o_range_rejected),
        .o_calibration_done (o_calibration_done)
    );

    // Calibrator state as the bench tracks it.
    logic signed [15:0] axis_lo [3];
    logic signed [15:0] axis_hi [3];
    logic [15:0]        n_valid;
    logic signed [16:0] ofs_sum [3];
    logic [15:0]        scale_q [3];
    bit                 collecting_m;
    bit                 calibrated_m;
    logic [15:0]        cfg_target;
    logic [14:0]        cfg_radius;
    logic [15:0]        cfg_min_mag;
    logic [15:0]        cfg_max_mag;

    t_reading pending_readings [$];
    int       items_sent;
    int       results_seen;
    int       mismatches;
    int       cycle_count;
    int       n_done;
    int       n_rejected;
    int       n_corrected;
    int       n_invalid;
    bit       calm;
    bit       long_hold_done;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial cycle_count = 0;
    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Timeout after %0d cycles with %0d results outstanding.", cycle_count,
                 pending_readings.size());
        $display("tb_magnetometer_minmax_calibrator_core failed");
        $finish;
    end

    function automatic void clear_extremes();
        for (int i = 0; i < 3; i++) begin
            axis_lo[i] = AXIS_MIN_RST;
            axis_hi[i] = AXIS_MAX_RST;
        end
        n_valid = '0;
    endfunction

    // Q2.14 scale: average span over this axis span, rounded half up.
    function automatic logic [15:0] axis_scale_of(input longint total, input longint span);
        longint q;
        if (span == 0) return 16'hFFFF;
        q = (2 * total * 16384 + 3 * span) / (6 * span);
        return (q > 65535) ? 16'hFFFF : q[15:0];
    endfunction

    function automatic logic signed [15:0] corrected_axis(input logic signed [15:0] raw,
                                                          input logic signed [16:0] ofs,
                                                          input logic [15:0] scl);
        longint p;
        p = (2 * longint'(raw) - longint'(ofs)) * longint'(scl);
        p = p >>> 15;
        if (p > 32767) p = 32767;
        if (p < -32768) p = -32768;
        return p[15:0];
    endfunction

    function automatic t_reading calibrate_reading(input logic mode,
                                                   input logic signed [15:0] rx,
                                                   input logic signed [15:0] ry,
                                                   input logic signed [15:0] rz);
        t_reading           r;
        logic signed [15:0] raw [3];
        logic signed [15:0] outv [3];
        longint             mag2;
        longint             lo2;
        longint             hi2;
        longint             total;
        longint             span [3];
        int                 d;
        int                 s;
        bit                 valid;
        bit                 small_span;
        bit                 applied;
        r = '0;
        if (mode == MODE_START) begin
            calibrated_m = 1'b0;
            collecting_m = 1'b1;
            for (int i = 0; i < 3; i++) begin
                ofs_sum[i] = '0;
                scale_q[i] = SCALE_ONE;
            end
            clear_extremes();
            r.calibrating = 1'b1;
            return r;
        end
        raw[0] = rx;
        raw[1] = ry;
        raw[2] = rz;
        mag2 = 0;
        for (int i = 0; i < 3; i++) mag2 += longint'(raw[i]) * longint'(raw[i]);
        lo2 = longint'(cfg_min_mag) * longint'(cfg_min_mag);
        hi2 = longint'(cfg_max_mag) * longint'(cfg_max_mag);
        valid = (mag2 >= lo2) && (mag2 <= hi2);
        if (!valid) n_invalid++;
        if (valid && collecting_m) begin
            for (int i = 0; i < 3; i++) begin
                if (raw[i] < axis_lo[i]) axis_lo[i] = raw[i];
                if (raw[i] > axis_hi[i]) axis_hi[i] = raw[i];
            end
            if (n_valid != 16'hFFFF) n_valid = n_valid + 16'd1;
            if (n_valid >= cfg_target) begin
                total = 0;
                small_span = 1'b0;
                for (int i = 0; i < 3; i++) begin
                    d = int'(axis_hi[i]) - int'(axis_lo[i]);
                    span[i] = (d > 0) ? longint'(d) : 0;
                    total += span[i];
                    if (span[i] < 2 * longint'(cfg_radius)) small_span = 1'b1;
                end
                if (small_span) begin
                    r.rejected = 1'b1;
                    n_rejected++;
                    clear_extremes();
                end else begin
                    for (int i = 0; i < 3; i++) begin
                        s = int'(axis_hi[i]) + int'(axis_lo[i]);
                        ofs_sum[i] = s[16:0];
                        scale_q[i] = axis_scale_of(total, span[i]);
                    end
                    collecting_m = 1'b0;
                    calibrated_m = 1'b1;
                    r.done = 1'b1;
                    n_done++;
                end
            end
        end
        applied = valid && calibrated_m;
        if (applied) n_corrected++;
        for (int i = 0; i < 3; i++)
            outv[i] = applied ? corrected_axis(raw[i], ofs_sum[i], scale_q[i]) : raw[i];
        r.fx = outv[0];
        r.fy = outv[1];
        r.fz = outv[2];
        r.sample_valid = valid;
        r.is_cal = applied;
        r.calibrating = collecting_m;
        r.taken = n_valid;
        return r;
    endfunction

    function automatic string reading_str(input t_reading r);
        return $sformatf({"x=%0d y=%0d z=%0d valid=%0b cal=%0b calibrating=%0b",
                          " taken=%0d rej=%0b done=%0b"},
                         r.fx, r.fy, r.fz, r.sample_valid, r.is_cal, r.calibrating, r.taken,
                         r.rejected, r.done);
    endfunction

    // Stimulus rows.
    function automatic t_stim_row cfg_row(input logic [15:0] target, input logic [15:0] radius,
                                          input logic [15:0] min_mag,
                                          input logic [15:0] max_mag);
        t_stim_row r;
        r = '0;
        r.is_cfg = 1'b1;
        r.target = target;
        r.radius = radius;
        r.min_mag = min_mag;
        r.max_mag = max_mag;
        return r;
    endfunction

    function automatic t_stim_row smp_row(input logic signed [15:0] x,
                                          input logic signed [15:0] y,
                                          input logic signed [15:0] z);
        t_stim_row r;
        r = '0;
        r.mode = MODE_SAMPLE;
        r.x = x;
        r.y = y;
        r.z = z;
        return r;
    endfunction

    // Valid sample straight after reset: passed through untouched.
    function automatic t_stim_row raw_row(input logic signed [15:0] x,
                                          input logic signed [15:0] y,
                                          input logic signed [15:0] z);
        t_stim_row r;
        r = smp_row(x, y, z);
        r.typed = 1'b1;
        r.want.fx = x;
        r.want.fy = y;
        r.want.fz = z;
        r.want.sample_valid = 1'b1;
        return r;
    endfunction

    // The raw fields of a start command carry random content that must be ignored.
    function automatic t_stim_row start_row();
        t_stim_row r;
        r = smp_row(16'($urandom), 16'($urandom), 16'($urandom));
        r.mode = MODE_START;
        r.typed = 1'b1;
        r.want.calibrating = 1'b1;
        return r;
    endfunction

    function automatic logic signed [15:0] cloud_axis(input int center, input int spread);
        int v;
        int r;
        r = $urandom_range(0, 2 * spread);
        v = center + r - spread;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[15:0];
    endfunction

    function automatic logic signed [15:0] corner_axis();
        case ($urandom_range(0, 2))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    task automatic load_settings(input t_stim_row row);
        write_reg(REG_SAMPLE_TARGET, row.target);
        write_reg(REG_MIN_AXIS_RADIUS, row.radius);
        write_reg(REG_MIN_VALID_MAG, row.min_mag);
        write_reg(REG_MAX_VALID_MAG, row.max_mag);
        i_cfg_we <= 1'b0;
        cfg_target = row.target;
        cfg_radius = row.radius[14:0];
        cfg_min_mag = row.min_mag;
        cfg_max_mag = row.max_mag;
    endtask

    // Registers only change while nothing is in flight.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_readings.size() != 0) @(posedge i_clk);
    endtask

    task automatic offer_item(input t_stim_row row);
        t_reading predicted;
        i_in_valid <= 1'b1;
        i_mode <= row.mode;
        i_raw_x <= row.x;
        i_raw_y <= row.y;
        i_raw_z <= row.z;
        do @(posedge i_clk); while (o_in_stall);
        predicted = calibrate_reading(row.mode, row.x, row.y, row.z);
        pending_readings.push_back(row.typed ? row.want : predicted);
        items_sent++;
        calm = (items_sent >= ITEM_GOAL - CALM_ITEMS);
    endtask

    task automatic pause_sender(input int pct);
        if (!calm && $urandom_range(0, 99) < pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
    endtask

    // Output side: random stall bursts, one long hold-off, result checking.
    initial begin : result_side
        int       hold;
        int       stall_pct;
        t_reading got;
        t_reading exp_r;
        string    bad;
        hold = 0;
        stall_pct = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                got.fx = o_field_x;
                got.fy = o_field_y;
                got.fz = o_field_z;
                got.sample_valid = o_sample_valid;
                got.is_cal = o_is_calibrated;
                got.calibrating = o_calibrating;
                got.taken = o_samples_taken;
                got.rejected = o_range_rejected;
                got.done = o_calibration_done;
                results_seen++;
                if (pending_readings.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected result %0d: %s", results_seen, reading_str(got));
                end else begin
                    exp_r = pending_readings.pop_front();
                    bad = "";
                    if (got.fx !== exp_r.fx) bad = {bad, " field_x"};
                    if (got.fy !== exp_r.fy) bad = {bad, " field_y"};
                    if (got.fz !== exp_r.fz) bad = {bad, " field_z"};
                    if (got.sample_valid !== exp_r.sample_valid) bad = {bad, " sample_valid"};
                    if (got.is_cal !== exp_r.is_cal) bad = {bad, " is_calibrated"};
                    if (got.calibrating !== exp_r.calibrating) bad = {bad, " calibrating"};
                    if (got.taken !== exp_r.taken) bad = {bad, " samples_taken"};
                    if (got.rejected !== exp_r.rejected) bad = {bad, " range_rejected"};
                    if (got.done !== exp_r.done) bad = {bad, " calibration_done"};
                    if (bad != "") begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("Mismatch on result %0d:%s", results_seen, bad);
                            $display("  expected %s", reading_str(exp_r));
                            $display("  actual   %s", reading_str(got));
                        end
                    end
                end
            end
            if (cycle_count % 128 == 0) begin
                case ($urandom_range(0, 2))
                    0: stall_pct = 0;
                    1: stall_pct = 10;
                    default: stall_pct = 35;
                endcase
            end
            if (hold > 0) begin
                hold--;
            end else if (!long_hold_done && items_sent >= 600) begin
                // Long hold-off so that both result slots fill and the input stalls.
                hold = LONG_HOLD;
                long_hold_done = 1'b1;
            end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
                hold = $urandom_range(1, 15);
            end
            i_out_stall <= (hold > 0);
        end
    end

    initial begin : stimulus
        t_stim_row dir_rows [$];
        t_stim_row row;
        int        gap_pct;
        int        phase_items;
        int        pick;
        int        phases;
        int        center [3];
        int        spread [3];
        logic [15:0] tgt;
        logic [15:0] rad;
        logic [15:0] mn;
        logic [15:0] mx;

        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_index <= REG_SAMPLE_TARGET;
        i_cfg_data <= '0;
        i_in_valid <= 1'b0;
        i_mode <= MODE_SAMPLE;
        i_raw_x <= '0;
        i_raw_y <= '0;
        i_raw_z <= '0;
        items_sent = 0;
        results_seen = 0;
        mismatches = 0;
        n_done = 0;
        n_rejected = 0;
        n_corrected = 0;
        n_invalid = 0;
        phases = 0;
        calm = 1'b0;
        long_hold_done = 1'b0;
        cfg_target = RST_SAMPLE_TARGET;
        cfg_radius = RST_MIN_RADIUS;
        cfg_min_mag = RST_MIN_MAG;
        cfg_max_mag = RST_MAX_MAG;
        clear_extremes();
        for (int i = 0; i < 3; i++) begin
            ofs_sum[i] = '0;
            scale_q[i] = SCALE_ONE;
        end
        collecting_m = 1'b0;
        calibrated_m = 1'b0;

        // Directed rows. The full-scale corners sit just inside the default
        // upper magnitude bound.
        dir_rows.push_back(raw_row(0, 0, 0));
        dir_rows.push_back(raw_row(32767, 32767, 32767));
        dir_rows.push_back(raw_row(-32768, -32768, -32768));
        dir_rows.push_back(smp_row(32767, -32768, 1));
        dir_rows.push_back(cfg_row(4, 100, 0, 56756));
        dir_rows.push_back(start_row());
        dir_rows.push_back(smp_row(1000, 200, -300));
        dir_rows.push_back(smp_row(-800, -400, 500));
        dir_rows.push_back(smp_row(300, 900, -700));
        dir_rows.push_back(smp_row(-200, -600, 100));
        dir_rows.push_back(smp_row(500, 500, 500));
        dir_rows.push_back(smp_row(32767, -32768, 0));
        // Tight cluster: the target is reached with spans far too short.
        dir_rows.push_back(start_row());
        dir_rows.push_back(smp_row(10, 10, 10));
        dir_rows.push_back(smp_row(11, 10, 10));
        dir_rows.push_back(smp_row(10, 12, 10));
        dir_rows.push_back(smp_row(10, 10, 13));
        // Target dropped to zero with zero radius: the next sample completes
        // with zero span on every axis.
        dir_rows.push_back(cfg_row(0, 0, 0, 56756));
        dir_rows.push_back(smp_row(-5, 7, -9));
        dir_rows.push_back(smp_row(-4, 100, -9));
        // Lower bound above the upper one: nothing is valid.
        dir_rows.push_back(cfg_row(1000, 50, 1000, 500));
        dir_rows.push_back(smp_row(0, 0, 0));
        dir_rows.push_back(smp_row(700, 0, 0));
        // Samples on and just off both magnitude bounds.
        dir_rows.push_back(cfg_row(1000, 50, 3, 5));
        dir_rows.push_back(smp_row(3, 4, 0));
        dir_rows.push_back(smp_row(0, 0, 3));
        dir_rows.push_back(smp_row(0, 0, 2));
        dir_rows.push_back(smp_row(6, 0, 0));

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[k]) begin
            if (dir_rows[k].is_cfg) begin
                drain_results();
                load_settings(dir_rows[k]);
            end else begin
                offer_item(dir_rows[k]);
                pause_sender(20);
            end
        end

        while (items_sent < ITEM_GOAL) begin
            phases++;
            case ($urandom_range(0, 5))
                0: tgt = 16'd1;
                1: tgt = 16'd65535;
                default: tgt = 16'($urandom_range(2, 40));
            endcase
            case ($urandom_range(0, 5))
                0: rad = 16'd0;
                1: rad = 16'd32767;
                default: rad = 16'($urandom_range(1, 3000));
            endcase
            case ($urandom_range(0, 9))
                0, 1: mn = 16'($urandom_range(0, 4000));
                2: mn = 16'd56756;
                3: mn = 16'($urandom);
                default: mn = 16'd0;
            endcase
            case ($urandom_range(0, 9))
                0, 1: mx = 16'($urandom_range(15000, 56756));
                2: mx = (mn == 0) ? 16'd0 : mn - 16'd1;
                3: mx = 16'($urandom);
                default: mx = 16'd56756;
            endcase
            drain_results();
            load_settings(cfg_row(tgt, rad, mn, mx));
            case ($urandom_range(0, 2))
                0: gap_pct = 0;
                1: gap_pct = 10;
                default: gap_pct = 30;
            endcase
            for (int c = 0; c < 3; c++) begin
                center[c] = int'($urandom_range(0, 8000)) - 4000;
                spread[c] = $urandom_range(100, 20000);
            end
            // Most phases open a fresh run; the rest carry on from the previous phase under new settings.
            if ($urandom_range(0, 4) != 0) begin
                offer_item(start_row());
                pause_sender(gap_pct);
            end
            phase_items = $urandom_range(40, 120);
            for (int n = 0; n < phase_items && items_sent < ITEM_GOAL; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 3)
                    row = start_row();
                else if (pick < 15)
                    row = smp_row(16'($urandom), 16'($urandom), 16'($urandom));
                else if (pick < 21)
                    row = smp_row(cloud_axis(0, 30), cloud_axis(0, 30), cloud_axis(0, 30));
                else if (pick < 25)
                    row = smp_row(corner_axis(), corner_axis(), corner_axis());
                else
                    row = smp_row(cloud_axis(center[0], spread[0]),
                                  cloud_axis(center[1], spread[1]),
                                  cloud_axis(center[2], spread[2]));
                offer_item(row);
                pause_sender(gap_pct);
            end
        end

        drain_results();
        repeat (150) @(posedge i_clk);
        $display("Sent %0d items over %0d random phases; %0d results checked, %0d mismatches.",
                 items_sent, phases, results_seen, mismatches);
        $display("Seen %0d calibrations, %0d short span restarts, %0d corrected and %0d %s",
                 n_done, n_rejected, n_corrected, n_invalid, "invalid samples.");
        if (mismatches == 0)
            $display("tb_magnetometer_minmax_calibrator_core passed");
        else
            $display("tb_magnetometer_minmax_calibrator_core failed");
        $finish;
    end

endmodule
